FILE: rtl/motm_pkg.sv
// ----------------------------------------------------------------------------
// motm_pkg
// Shared types and constants for the motor overcurrent trip monitor.
// ----------------------------------------------------------------------------
package motm_pkg;

  localparam int CURRENT_WIDTH_DEFAULT = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICK        = 3'd4;

  localparam int LIMIT_W      = 15;
  localparam int LIMIT_SQ_W   = 2 * LIMIT_W;
  localparam int SQ49_W       = LIMIT_SQ_W + 6;
  localparam int TIME_LIMIT_W = 16;
  localparam int TICK_W       = 10;
  localparam int FAULT_W      = 8;
  localparam int ACC_W        = 17;

  localparam logic [ACC_W-1:0]  ACC_MAX    = '1;
  localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

  typedef struct packed {
    logic [SQ49_W-1:0]       motor_sq49;
    logic [LIMIT_SQ_W-1:0]   ctrl_sq;
    logic [LIMIT_W-1:0]      d_limit;
    logic                    motor_on;
    logic                    ctrl_on;
    logic                    d_on;
    logic [TIME_LIMIT_W-1:0] time_limit;
    logic [TICK_W-1:0]       tick;
  } cfg_t;

endpackage

FILE: rtl/motm_cfg.sv
// ----------------------------------------------------------------------------
// motm_cfg
// Configuration registers and the limit squares derived from them.
// ----------------------------------------------------------------------------
module motm_cfg
  import motm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam int X7_W = LIMIT_W + 3;

  logic [LIMIT_W-1:0]      motor_limit;
  logic [LIMIT_W-1:0]      ctrl_limit;
  logic [LIMIT_W-1:0]      d_limit;
  logic [TIME_LIMIT_W-1:0] time_limit;
  logic [TICK_W-1:0]       tick;
  logic [LIMIT_SQ_W-1:0]   ctrl_sq;
  logic [SQ49_W-1:0]       motor_sq49;
  logic [LIMIT_W-1:0]      data_lim;
  logic [X7_W-1:0]         data_x7;

  assign cfg_ready = 1'b1;

  // 49 * L * L as (8L - L) squared
  assign data_lim = cfg_data[LIMIT_W-1:0];
  assign data_x7  = (X7_W'(data_lim) << 3) - X7_W'(data_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_limit <= '0;
      ctrl_limit  <= '0;
      d_limit     <= '0;
      time_limit  <= '0;
      tick        <= TICK_RESET;
      motor_sq49  <= '0;
      ctrl_sq     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOTOR_LIMIT: begin
          motor_limit <= data_lim;
          motor_sq49  <= SQ49_W'(data_x7) * SQ49_W'(data_x7);
        end
        REG_CTRL_LIMIT: begin
          ctrl_limit <= data_lim;
          ctrl_sq    <= LIMIT_SQ_W'(data_lim) * LIMIT_SQ_W'(data_lim);
        end
        REG_D_LIMIT:     d_limit     <= data_lim;
        REG_TIME_LIMIT:  time_limit  <= cfg_data[TIME_LIMIT_W-1:0];
        REG_TICK:        tick        <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.motor_sq49 = motor_sq49;
    cfg.ctrl_sq    = ctrl_sq;
    cfg.d_limit    = d_limit;
    cfg.motor_on   = (motor_limit != '0);
    cfg.ctrl_on    = (ctrl_limit != '0);
    cfg.d_on       = (d_limit != '0);
    cfg.time_limit = time_limit;
    cfg.tick       = tick;
  end

endmodule

FILE: rtl/motm_mag.sv
// ----------------------------------------------------------------------------
// motm_mag
// Input register and the squared magnitude of the held sample.
// ----------------------------------------------------------------------------
module motm_mag
  import motm_pkg::*;
#(
  parameter int CURRENT_WIDTH = CURRENT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [CURRENT_WIDTH-1:0] q_axis_current,
  input  logic signed [CURRENT_WIDTH-1:0] d_axis_current,
  input  logic [FAULT_W-1:0]              fault_code,
  output logic                            mag_valid,
  input  logic                            mag_ready,
  output logic [2*CURRENT_WIDTH-1:0]      mag2,
  output logic [2*CURRENT_WIDTH+6:0]      mag100,
  output logic [CURRENT_WIDTH-1:0]        d_abs,
  output logic                            fault_seen
);

  localparam int W     = CURRENT_WIDTH;
  localparam int SUM_W = 2 * W;
  localparam int HUN_W = 2 * W + 7;

  logic             en;
  logic [W-1:0]     q_word, d_word;
  logic [W-1:0]     q_abs;
  logic [SUM_W-1:0] q_sq, d_sq;
  logic [HUN_W-1:0] sum_ext;

  assign en       = !mag_valid || mag_ready;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (en) begin
      mag_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      q_word     <= q_axis_current;
      d_word     <= d_axis_current;
      fault_seen <= (fault_code != '0);
    end
  end

  // exact magnitudes, squared sum and 100 * sum (64 + 32 + 4)
  assign q_abs   = q_word[W-1] ? (~q_word + W'(1)) : q_word;
  assign d_abs   = d_word[W-1] ? (~d_word + W'(1)) : d_word;
  assign q_sq    = SUM_W'(q_abs) * SUM_W'(q_abs);
  assign d_sq    = SUM_W'(d_abs) * SUM_W'(d_abs);
  assign mag2    = q_sq + d_sq;
  assign sum_ext = HUN_W'(mag2);
  assign mag100  = (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);

endmodule

FILE: rtl/motm_judge.sv
// ----------------------------------------------------------------------------
// motm_judge
// Limit checks, leaky violation timer, trip latch and result register.
// ----------------------------------------------------------------------------
module motm_judge
  import motm_pkg::*;
#(
  parameter int CURRENT_WIDTH = CURRENT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       mag_valid,
  output logic                       mag_ready,
  input  logic [2*CURRENT_WIDTH-1:0] mag2,
  input  logic [2*CURRENT_WIDTH+6:0] mag100,
  input  logic [CURRENT_WIDTH-1:0]   d_abs,
  input  logic                       fault_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       tripped,
  output logic                       any_violation,
  output logic                       motor_over,
  output logic                       controller_over,
  output logic                       d_axis_over,
  output logic                       fault_seen,
  output logic [ACC_W-1:0]           violation_time
);

  localparam int W      = CURRENT_WIDTH;
  localparam int SUM_W  = 2 * W;
  localparam int HUN_W  = 2 * W + 7;
  localparam int MOT_CW = (HUN_W > SQ49_W) ? HUN_W : SQ49_W;
  localparam int CTL_CW = (SUM_W > LIMIT_SQ_W) ? SUM_W : LIMIT_SQ_W;
  localparam int D_CW   = (W > LIMIT_W) ? W : LIMIT_W;

  logic             take;
  logic             motor_next, ctrl_next, d_next, any_next;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] tick_ext;
  logic [ACC_W-1:0] acc_next;
  logic             trip_next;

  assign mag_ready = !out_valid || !out_stall;
  assign take      = mag_valid && mag_ready;

  always_comb begin
    motor_next = cfg.motor_on && (MOT_CW'(mag100) > MOT_CW'(cfg.motor_sq49));
    ctrl_next  = cfg.ctrl_on && (CTL_CW'(mag2) > CTL_CW'(cfg.ctrl_sq));
    d_next     = cfg.d_on && (D_CW'(d_abs) > D_CW'(cfg.d_limit));
    any_next   = motor_next || ctrl_next || d_next || fault_in;

    tick_ext = ACC_W'(cfg.tick);
    acc_sum  = (ACC_W + 1)'(violation_time) + (ACC_W + 1)'(tick_ext);
    if (any_next) begin
      acc_next = (acc_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
    end else if (violation_time > tick_ext) begin
      acc_next = violation_time - tick_ext;
    end else begin
      acc_next = '0;
    end
    trip_next = tripped || (any_next && (acc_next > ACC_W'(cfg.time_limit)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      tripped        <= 1'b0;
      violation_time <= '0;
    end else begin
      if (mag_ready) out_valid <= mag_valid;
      if (take) begin
        tripped        <= trip_next;
        violation_time <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      any_violation   <= any_next;
      motor_over      <= motor_next;
      controller_over <= ctrl_next;
      d_axis_over     <= d_next;
      fault_seen      <= fault_in;
    end
  end

endmodule

FILE: rtl/motor_overcurrent_trip_monitor.sv
// ----------------------------------------------------------------------------
// motor_overcurrent_trip_monitor
// Per-sample overcurrent checks with a leaky violation timer and sticky trip.
// ----------------------------------------------------------------------------
// Input channel: one word per sample (q and d current, fault code), taken
// when in_valid is high and in_stall low. Output channel: one result word
// per sample, handed over when out_valid is high and out_stall low.
// The block takes one word every cycle unless the output stalls. Two register
// stages: the input register, then checks and timer update from the held
// sample into the result register.
// Configuration goes through cfg_valid/cfg_ready (always ready), cfg_index
// selects the register; unknown indexes are ignored. Write only while idle.
// Reset clears the pipeline, the timer and the trip latch, and loads the
// register defaults (limits zero, tick interval 10 ms).
// A stalled output holds its word; the input register fills behind it and
// then raises in_stall, so no word is dropped.
// ----------------------------------------------------------------------------
module motor_overcurrent_trip_monitor
  import motm_pkg::*;
#(
  parameter int CURRENT_WIDTH = CURRENT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [CURRENT_WIDTH-1:0] q_axis_current,
  input  logic signed [CURRENT_WIDTH-1:0] d_axis_current,
  input  logic [FAULT_W-1:0]              fault_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            tripped,
  output logic                            any_violation,
  output logic                            motor_over,
  output logic                            controller_over,
  output logic                            d_axis_over,
  output logic                            fault_seen,
  output logic [ACC_W-1:0]                violation_time
);

  cfg_t                       cfg;
  logic                       mag_valid;
  logic                       mag_ready;
  logic [2*CURRENT_WIDTH-1:0] mag2;
  logic [2*CURRENT_WIDTH+6:0] mag100;
  logic [CURRENT_WIDTH-1:0]   d_abs;
  logic                       fault_mid;

  motm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  motm_mag #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
  ) u_mag (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .q_axis_current (q_axis_current),
    .d_axis_current (d_axis_current),
    .fault_code     (fault_code),
    .mag_valid      (mag_valid),
    .mag_ready      (mag_ready),
    .mag2           (mag2),
    .mag100         (mag100),
    .d_abs          (d_abs),
    .fault_seen     (fault_mid)
  );

  motm_judge #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
  ) u_judge (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .mag_valid       (mag_valid),
    .mag_ready       (mag_ready),
    .mag2            (mag2),
    .mag100          (mag100),
    .d_abs           (d_abs),
    .fault_in        (fault_mid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tripped         (tripped),
    .any_violation   (any_violation),
    .motor_over      (motor_over),
    .controller_over (controller_over),
    .d_axis_over     (d_axis_over),
    .fault_seen      (fault_seen),
    .violation_time  (violation_time)
  );

endmodule

FILE: test/tb_motor_overcurrent_trip_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_overcurrent_trip_monitor
// Drives current samples through the trip monitor and checks every result
// word against an in-bench model of the four protection checks, the leaky
// violation timer and the sticky trip. A directed sequence walks the limit
// boundaries, the strict trip test and the timer floor. Random phases then
// sweep register settings, including tick interval zero and saturation, under
// bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module tb_motor_overcurrent_trip_monitor;
  import motm_pkg::*;

  localparam int          CUR_W       = CURRENT_WIDTH_DEFAULT;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned REG_COUNT   = 5;
  localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic             tripped;
    logic             any_violation;
    logic             motor_over;
    logic             controller_over;
    logic             d_axis_over;
    logic             fault_seen;
    logic [ACC_W-1:0] violation_time;
  } trip_result_t;

  class overcurrent_scoreboard;
    longint unsigned motor_lim;
    longint unsigned ctrl_lim;
    longint unsigned d_lim;
    longint unsigned time_lim;
    longint unsigned tick;
    longint unsigned accum;
    bit              latched;
    int unsigned     errors;
    trip_result_t    expected_results[$];

    function new();
      motor_lim = 0;
      ctrl_lim  = 0;
      d_lim     = 0;
      time_lim  = 0;
      tick      = TICK_RESET;
      accum     = 0;
      latched   = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MOTOR_LIMIT: motor_lim = data[LIMIT_W-1:0];
        REG_CTRL_LIMIT:  ctrl_lim  = data[LIMIT_W-1:0];
        REG_D_LIMIT:     d_lim     = data[LIMIT_W-1:0];
        REG_TIME_LIMIT:  time_lim  = data[TIME_LIMIT_W-1:0];
        REG_TICK:        tick      = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned magnitude(logic signed [CUR_W-1:0] v);
      logic signed [CUR_W:0] w;
      w = v;
      if (w < 0) w = -w;
      return longint'(unsigned'(w));
    endfunction

    function trip_result_t evaluate_sample(logic signed [CUR_W-1:0] q,
                                           logic signed [CUR_W-1:0] d,
                                           logic [FAULT_W-1:0] f);
      longint unsigned qa, da, mag2, sum;
      trip_result_t r;
      qa   = magnitude(q);
      da   = magnitude(d);
      mag2 = qa * qa + da * da;
      r.motor_over      = (motor_lim != 0) && (100 * mag2 > 49 * motor_lim * motor_lim);
      r.controller_over = (ctrl_lim != 0) && (mag2 > ctrl_lim * ctrl_lim);
      r.d_axis_over     = (d_lim != 0) && (da > d_lim);
      r.fault_seen      = (f != 0);
      r.any_violation   = r.motor_over | r.controller_over | r.d_axis_over | r.fault_seen;
      if (r.any_violation) begin
        sum   = accum + tick;
        accum = (sum > ACC_MAX) ? ACC_MAX : sum;
        if (accum > time_lim) latched = 1'b1;
      end else begin
        accum = (accum > tick) ? accum - tick : 0;
      end
      r.tripped        = latched;
      r.violation_time = accum[ACC_W-1:0];
      return r;
    endfunction

    function void note_sample(logic signed [CUR_W-1:0] q, logic signed [CUR_W-1:0] d,
                              logic [FAULT_W-1:0] f);
      expected_results.insert(expected_results.size(), evaluate_sample(q, d, f));
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(trip_result_t got);
      trip_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result word with none expected, expected none, got %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("tripped", want.tripped, got.tripped);
      compare_field("any_violation", want.any_violation, got.any_violation);
      compare_field("motor_over", want.motor_over, got.motor_over);
      compare_field("controller_over", want.controller_over, got.controller_over);
      compare_field("d_axis_over", want.d_axis_over, got.d_axis_over);
      compare_field("fault_seen", want.fault_seen, got.fault_seen);
      compare_field("violation_time", want.violation_time, got.violation_time);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CUR_W-1:0] q_axis_current = '0;
  logic signed [CUR_W-1:0] d_axis_current = '0;
  logic [FAULT_W-1:0]      fault_code = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    tripped;
  logic                    any_violation;
  logic                    motor_over;
  logic                    controller_over;
  logic                    d_axis_over;
  logic                    fault_seen;
  logic [ACC_W-1:0]        violation_time;

  logic        hold_req = 1'b0;
  bit          gaps_on = 1'b1;
  bit          no_gaps = 1'b0;
  int unsigned burst_left = 0;

  overcurrent_scoreboard monitor = new();

  motor_overcurrent_trip_monitor #(.CURRENT_WIDTH(CUR_W)) u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .q_axis_current  (q_axis_current),
    .d_axis_current  (d_axis_current),
    .fault_code      (fault_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tripped         (tripped),
    .any_violation   (any_violation),
    .motor_over      (motor_over),
    .controller_over (controller_over),
    .d_axis_over     (d_axis_over),
    .fault_seen      (fault_seen),
    .violation_time  (violation_time)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    monitor.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] m, logic [CFG_DATA_W-1:0] c,
                              logic [CFG_DATA_W-1:0] dl, logic [CFG_DATA_W-1:0] tl,
                              logic [CFG_DATA_W-1:0] tk);
    write_reg(REG_MOTOR_LIMIT, m);
    write_reg(REG_CTRL_LIMIT, c);
    write_reg(REG_D_LIMIT, dl);
    write_reg(REG_TIME_LIMIT, tl);
    write_reg(REG_TICK, tk);
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_COUNT)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(logic signed [CUR_W-1:0] q, logic signed [CUR_W-1:0] d,
                             logic [FAULT_W-1:0] f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gaps_on && !no_gaps) ? $urandom_range(8, 1) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(30, 1);
      gaps_on    = ($urandom_range(4, 0) != 0);
    end
    q_axis_current <= q;
    d_axis_current <= d;
    fault_code     <= f;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    monitor.note_sample(q, d, f);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (monitor.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CUR_W-1:0] rand_current(longint unsigned lim);
    int span, v;
    span = (lim == 0) ? 32767 : int'(lim + lim / 2);
    if (span > 32767) span = 32767;
    case ($urandom_range(9, 0))
      0: return {1'b1, {(CUR_W-1){1'b0}}};
      1: return {1'b0, {(CUR_W-1){1'b1}}};
      2: return '0;
      3, 4: return CUR_W'($urandom);
      default: begin
        v = int'($urandom_range(2 * span, 0)) - span;
        return CUR_W'(v);
      end
    endcase
  endfunction

  function automatic longint unsigned pick_limit();
    case ($urandom_range(2, 0))
      0: return monitor.motor_lim * 7 / 10;
      1: return monitor.ctrl_lim;
      default: return monitor.d_lim;
    endcase
  endfunction

  task automatic run_random(int unsigned count, int unsigned fault_pct);
    logic [FAULT_W-1:0] f;
    repeat (count) begin
      f = ($urandom_range(99, 0) < fault_pct) ? FAULT_W'($urandom_range(255, 1)) : '0;
      push_sample(rand_current(pick_limit()), rand_current(pick_limit()), f);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_limit(int unsigned top);
    return CFG_DATA_W'($urandom_range(top, 1));
  endfunction

  initial begin : result_sink
    int unsigned  mode, left, hold_left;
    trip_result_t got;
    mode      = 0;
    left      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got.tripped         = tripped;
        got.any_violation   = any_violation;
        got.motor_over      = motor_over;
        got.controller_over = controller_over;
        got.d_axis_over     = d_axis_over;
        got.fault_seen      = fault_seen;
        got.violation_time  = violation_time;
        monitor.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3, 0);
          left = $urandom_range(80, 10);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3, 0) == 0);
          2: out_stall <= ($urandom_range(9, 0) < 7);
          default: out_stall <= left[0];
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // limits disabled: full-scale currents raise nothing
    program_regs('0, '0, '0, 16'd65535, 16'd10);
    push_sample(16'sh8000, 16'sh8000, 8'd0);
    drain();

    program_regs(16'd1000, 16'd2000, 16'd500, 16'd25, 16'd5);
    push_sample(16'sd0, 16'sd0, 8'd0);
    push_sample(16'sd700, 16'sd0, 8'd0);
    push_sample(16'sd701, 16'sd0, 8'd0);
    push_sample(-16'sd2000, 16'sd0, 8'd0);
    push_sample(-16'sd2001, 16'sd0, 8'd0);
    push_sample(16'sd0, -16'sd500, 8'd0);
    push_sample(16'sd0, 16'sd501, 8'd0);
    push_sample(16'sd0, 16'sd0, 8'd1);
    push_sample(16'sd0, 16'sd0, 8'd255);
    repeat (6) push_sample(16'sd0, 16'sd0, 8'd0);
    push_sample(16'sh8000, 16'sh8000, 8'd0);
    push_sample(16'sh7FFF, 16'sh7FFF, 8'd0);
    push_sample(16'sh8000, 16'sd0, 8'd0);
    drain();

    // larger tick than what is left: floor at zero
    program_regs(16'd1000, 16'd2000, 16'd500, 16'd25, 16'd7);
    repeat (3) push_sample(16'sd0, 16'sd0, 8'd0);
    drain();

    program_regs(rand_limit(32767), rand_limit(32767), rand_limit(32767), 16'd65535,
                 16'($urandom_range(16, 1)));
    run_random(500, 10);
    drain();

    program_regs(rand_limit(300), rand_limit(300), rand_limit(300), 16'd65535,
                 16'($urandom_range(16, 1)));
    run_random(100, 5);
    hold_req <= 1'b1;
    no_gaps = 1'b1;
    run_random(60, 5);
    no_gaps = 1'b0;
    run_random(140, 5);
    drain();

    program_regs(rand_limit(2000), rand_limit(2000), rand_limit(2000),
                 16'($urandom_range(200, 0)), ALL_ONES);
    run_random(250, 30);
    drain();

    program_regs(ALL_ONES, ALL_ONES, ALL_ONES, '0, '0);
    run_random(150, 20);
    drain();

    program_regs(rand_limit(32767), rand_limit(32767), rand_limit(32767), 16'd65535,
                 16'd1000);
    run_random(200, 15);
    drain();

    program_regs(rand_limit(32767), rand_limit(32767), rand_limit(32767),
                 16'($urandom), 16'd1);
    run_random(200, 15);
    drain();

    program_regs('0, rand_limit(32767), '0, 16'($urandom),
                 16'($urandom_range(1000, 1)));
    run_random(200, 50);
    drain();

    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom_range(1000, 1)));
    run_random(100, 10);
    drain();

    repeat (10) @(posedge clk);
    if (monitor.errors == 0 && monitor.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
